@@ hw/rtl/wcdf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcdf_pkg
// Shared sizes and item types of the weight cdf builder.
// ----------------------------------------------------------------------------
package wcdf_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int WEIGHT_BITS = 32;
	localparam int FRAC_BITS   = 16;

	localparam int IDX_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
	localparam int TOTAL_BITS = WEIGHT_BITS + IDX_BITS;
	localparam int QUOT_BITS  = FRAC_BITS + 1;
	localparam int STEP_BITS  = $clog2(QUOT_BITS);

	// fixed widths of the item fields
	localparam int WEIGHT_W = 32;
	localparam int CDF_W    = 17;
	localparam int INDEX_W  = 6;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                last_weight;
	} load_t;

	typedef struct packed {
		logic [CDF_W-1:0]   cdf_value;
		logic [INDEX_W-1:0] entry_index;
		logic               last_entry;
		logic               uniform_used;
		logic               dropped_weights;
	} result_t;

endpackage

@@ hw/rtl/weight_cdf_builder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_cdf_builder_core
// Running prefix sums of a weight set, then a normalized cdf per entry.
// ----------------------------------------------------------------------------
// Usage:
//   A weight item is taken at a rising edge with start high and busy low.
//   While loading, busy stays low and one weight per cycle is accepted; each
//   is added to the running total and the prefix sum written to the store.
//   Weights beyond MAX_ENTRIES are dropped and reported on every result.
//   The item with last_weight set raises busy and starts the output pass.
//   For each entry the core does one store read, one divider setup and
//   QUOT_BITS (17) steps of a shared restoring divider, one quotient bit per
//   cycle. The results come out in index order, each on result for exactly
//   one cycle with strobe high; the receiver cannot stall them.
//   Busy stays high through the whole output pass of a set and drops in
//   the cycle where the final entry is on the result port.
//   Reset clears the sequencer, total, count and drop flag; the prefix
//   store has no reset and is only read at entries written for the set.
// ----------------------------------------------------------------------------
module weight_cdf_builder_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  wcdf_pkg::load_t   load,
	output logic              strobe,
	output wcdf_pkg::result_t result
);
	import wcdf_pkg::*;

	localparam logic [1:0] S_LOAD = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_INIT = 2'd2;
	localparam logic [1:0] S_DIV  = 2'd3;

	localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(QUOT_BITS - 1);

	logic [1:0]            state_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  ovf_q;
	logic                  uniform_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [TOTAL_BITS-1:0] rem_q;
	logic [FRAC_BITS:0]    dsh_q;
	logic [FRAC_BITS-1:0]  quot_q;
	logic [TOTAL_BITS-1:0] rd_q;

	logic [TOTAL_BITS-1:0] prefix_mem [MAX_ENTRIES];

	logic                  accept;
	logic                  has_room;
	logic [TOTAL_BITS-1:0] next_total;
	logic [TOTAL_BITS-1:0] num;
	logic [TOTAL_BITS-1:0] den;
	logic [TOTAL_BITS:0]   trial;
	logic                  ge;
	logic                  is_last;

	assign busy     = (state_q != S_LOAD);
	assign accept   = start && !busy;
	assign has_room = (count_q < CNT_BITS'(MAX_ENTRIES));
	assign next_total = total_q + TOTAL_BITS'(load.weight[WEIGHT_BITS-1:0]);

	assign num = uniform_q ? (TOTAL_BITS'(idx_q) + TOTAL_BITS'(1)) : rd_q;
	assign den = uniform_q ? TOTAL_BITS'(count_q) : total_q;

	// one restoring step: bring down the next dividend bit, try the subtract
	assign trial   = {rem_q, dsh_q[FRAC_BITS]};
	assign ge      = (trial >= {1'b0, den});
	assign is_last = ((CNT_BITS'(idx_q) + CNT_BITS'(1)) == count_q);

	always_ff @(posedge clk) begin
		if (accept && has_room) begin
			prefix_mem[count_q[IDX_BITS-1:0]] <= next_total;
		end
		rd_q <= prefix_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_INIT: begin
				rem_q  <= num >> 1;
				dsh_q  <= {num[0], {FRAC_BITS{1'b0}}};
				quot_q <= '0;
			end
			S_DIV: begin
				rem_q  <= ge ? TOTAL_BITS'(trial - {1'b0, den}) : trial[TOTAL_BITS-1:0];
				dsh_q  <= dsh_q << 1;
				quot_q <= {quot_q[FRAC_BITS-2:0], ge};
			end
			default: begin
			end
		endcase
		if (state_q == S_DIV && step_q == LAST_STEP) begin
			result.cdf_value       <= CDF_W'({quot_q, ge});
			result.entry_index     <= INDEX_W'(idx_q);
			result.last_entry      <= is_last;
			result.uniform_used    <= uniform_q;
			result.dropped_weights <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			total_q   <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			uniform_q <= 1'b0;
			idx_q     <= '0;
			step_q    <= '0;
			strobe    <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (has_room) begin
							total_q <= next_total;
							count_q <= count_q + CNT_BITS'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (load.last_weight) begin
							uniform_q <= has_room ? (next_total == '0) : (total_q == '0);
							idx_q     <= '0;
							state_q   <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_INIT;
				end
				S_INIT: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + STEP_BITS'(1);
					if (step_q == LAST_STEP) begin
						strobe <= 1'b1;
						if (is_last) begin
							total_q <= '0;
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							idx_q   <= idx_q + IDX_BITS'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// a result only follows the final divider step
	a_strobe_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) == S_DIV && $past(step_q) == LAST_STEP)
		else $error("result strobe without a finished division");

	// normalized values never exceed one
	a_cdf_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> result.cdf_value <= CDF_W'(1 << FRAC_BITS))
		else $error("cdf value above one");

	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < den)
		else $error("divider remainder out of range");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_ENTRIES))
		else $error("entry count above capacity");

	// the final entry clears the load state and frees the input
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_entry |-> count_q == '0 && !busy)
		else $error("load state not cleared after final entry");

endmodule
